FILE: rtl/core/wtsp_pkg.sv
// ----------------------------------------------------------------------------
// wtsp_pkg
// Shared types and codes for the world-to-screen projection core.
// ----------------------------------------------------------------------------
`default_nettype none

package wtsp_pkg;

    // input word
    typedef struct packed {
        logic               mode;
        logic [4:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
    } in_t;

    // result word
    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] screen_x;
        logic [16:0] screen_y;
    } out_t;

    // control that travels with a word through the transform stages
    typedef struct packed {
        logic        vld;
        logic        proj;
        logic [4:0]  cidx;
        logic [31:0] cval;
    } ctl_t;

    // control that travels with a word through the divider
    typedef struct packed {
        logic       vld;
        logic [1:0] status;
    } tag_t;

    localparam logic [1:0] ST_ON_SCREEN  = 2'd0;
    localparam logic [1:0] ST_INVALID    = 2'd1;
    localparam logic [1:0] ST_BEHIND     = 2'd2;
    localparam logic [1:0] ST_OFF_SCREEN = 2'd3;

    localparam logic [1:0] CFG_MATRICES_VALID = 2'd0;
    localparam logic [1:0] CFG_SCREEN_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_SCREEN_HEIGHT  = 2'd2;

    localparam int CfgDataW = 13;
    localparam int ScaleW   = 16;   // screen size * 8
    localparam int QuotW    = 17;   // screen coordinate bits

endpackage

`default_nettype wire

FILE: rtl/core/wtsp_qmul.sv
// ----------------------------------------------------------------------------
// wtsp_qmul
// Registered fixed-point multiply: truncate toward zero, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module wtsp_qmul #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                clk,
    input  wire logic                adv,
    input  wire logic signed [W-1:0] a,
    input  wire logic signed [W-1:0] b,
    output      logic signed [W-1:0] p
);

    localparam logic signed [2*W-1:0] BIAS = {{(2*W-F){1'b0}}, {F{1'b1}}};

    logic signed [2*W-1:0] prod;
    logic signed [2*W-1:0] shr;
    logic signed [W-1:0]   p_next;
    logic signed [W-1:0]   p_reg;

    always_comb
    begin
        prod = a * b;
        if (prod[2*W-1])
        begin
            shr = (prod + BIAS) >>> F;
        end
        else
        begin
            shr = prod >>> F;
        end
        if ((&shr[2*W-1:W-1]) || !(|shr[2*W-1:W-1]))
        begin
            p_next = shr[W-1:0];
        end
        else
        begin
            p_next = shr[2*W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

FILE: rtl/core/wtsp_view.sv
// ----------------------------------------------------------------------------
// wtsp_view
// World to view space: 12 products, then sums with the translation row.
// Holds the view matrix; loads land as they pass the product stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wtsp_view #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire wtsp_pkg::ctl_t      ctl_in,
    input  wire logic signed [31:0]  wx,
    input  wire logic signed [31:0]  wy,
    input  wire logic signed [31:0]  wz,
    output      wtsp_pkg::ctl_t      ctl_out,
    output      logic signed [W-1:0] view_out [4]
);

    function automatic logic signed [W-1:0] from32(input logic signed [31:0] v);
        logic signed [W+31:0] e;
        e = (W+32)'(v);
        if ((&e[W+31:W-1]) || !(|e[W+31:W-1]))
        begin
            from32 = e[W-1:0];
        end
        else
        begin
            from32 = e[W+31] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    logic signed [W-1:0] coef_reg [16];
    logic signed [W-1:0] world [3];
    logic signed [W-1:0] prod [3][4];
    logic signed [W-1:0] row3_reg [4];
    logic signed [W-1:0] view_reg [4];
    logic signed [W-1:0] view_next [4];
    wtsp_pkg::ctl_t      ctl1_reg;
    wtsp_pkg::ctl_t      ctl2_reg;

    assign world[0] = from32(wx);
    assign world[1] = from32(wy);
    assign world[2] = from32(wz);

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 4; c++)
        begin : g_col
            wtsp_qmul #(.W(W), .F(F)) u_mul (
                .clk (clk),
                .adv (adv),
                .a   (world[r]),
                .b   (coef_reg[r*4+c]),
                .p   (prod[r][c])
            );
        end
    end

    always_comb
    begin
        logic signed [W+1:0] s;
        for (int c = 0; c < 4; c++)
        begin
            s = (W+2)'(prod[0][c]) + (W+2)'(prod[1][c]) + (W+2)'(prod[2][c])
                + (W+2)'(row3_reg[c]);
            if ((&s[W+1:W-1]) || !(|s[W+1:W-1]))
            begin
                view_next[c] = s[W-1:0];
            end
            else
            begin
                view_next[c] = s[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                row3_reg[c] <= coef_reg[12+c];
                view_reg[c] <= view_next[c];
            end
            if (ctl_in.vld && !ctl_in.proj && !ctl_in.cidx[4])
            begin
                coef_reg[ctl_in.cidx[3:0]] <= from32($signed(ctl_in.cval));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (adv)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    assign ctl_out  = ctl2_reg;
    assign view_out = view_reg;

endmodule

`default_nettype wire

FILE: rtl/core/wtsp_clip.sv
// ----------------------------------------------------------------------------
// wtsp_clip
// View to clip space (x, y, w), reject tests, and dividend scaling.
// Holds the projection matrix; loads land as they pass the product stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wtsp_clip #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    adv,
    input  wire wtsp_pkg::ctl_t                          ctl_in,
    input  wire logic signed [W-1:0]                     view_in [4],
    input  wire logic                                    mat_valid,
    input  wire logic [wtsp_pkg::CfgDataW-1:0]           width,
    input  wire logic [wtsp_pkg::CfgDataW-1:0]           height,
    output      wtsp_pkg::tag_t                          tag_out,
    output      logic [W+wtsp_pkg::ScaleW-1:0]           dx,
    output      logic [W+wtsp_pkg::ScaleW-1:0]           dy,
    output      logic [W-1:0]                            den
);

    localparam int DW = W + wtsp_pkg::ScaleW;
    localparam logic signed [W-1:0] ONE_TENTH = W'(((1 << F) + 5) / 10);

    function automatic logic signed [W-1:0] from32(input logic signed [31:0] v);
        logic signed [W+31:0] e;
        e = (W+32)'(v);
        if ((&e[W+31:W-1]) || !(|e[W+31:W-1]))
        begin
            from32 = e[W-1:0];
        end
        else
        begin
            from32 = e[W+31] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    logic signed [W-1:0] coef_reg [16];
    logic signed [W-1:0] prod [4][3];
    logic signed [W-1:0] clip_next [3];
    logic signed [W-1:0] clip_reg [3];
    wtsp_pkg::ctl_t      ctl3_reg;
    wtsp_pkg::ctl_t      ctl4_reg;
    wtsp_pkg::tag_t      tag5_reg;
    wtsp_pkg::tag_t      tag6_reg;
    wtsp_pkg::tag_t      tag5_next;
    logic [W-1:0]        numx_reg;
    logic [W-1:0]        numy_reg;
    logic [W-1:0]        den5_reg;
    logic [W-1:0]        numx_next;
    logic [W-1:0]        numy_next;
    logic [DW-1:0]       dx_reg;
    logic [DW-1:0]       dy_reg;
    logic [W-1:0]        den6_reg;

    // lanes 0, 1, 2 use matrix columns 0, 1, 3 (clip x, y, w)
    for (genvar r = 0; r < 4; r++)
    begin : g_row
        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            wtsp_qmul #(.W(W), .F(F)) u_mul (
                .clk (clk),
                .adv (adv),
                .a   (view_in[r]),
                .b   (coef_reg[r*4 + ((j == 2) ? 3 : j)]),
                .p   (prod[r][j])
            );
        end
    end

    always_comb
    begin
        logic signed [W+1:0] s;
        for (int j = 0; j < 3; j++)
        begin
            s = (W+2)'(prod[0][j]) + (W+2)'(prod[1][j]) + (W+2)'(prod[2][j])
                + (W+2)'(prod[3][j]);
            if ((&s[W+1:W-1]) || !(|s[W+1:W-1]))
            begin
                clip_next[j] = s[W-1:0];
            end
            else
            begin
                clip_next[j] = s[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
        end
    end

    // reject tests and dividend numerators
    always_comb
    begin
        logic signed [W:0] cx;
        logic signed [W:0] cy;
        logic signed [W:0] cw;
        logic signed [W:0] sx;
        logic signed [W:0] sy;
        cx = (W+1)'(clip_reg[0]);
        cy = (W+1)'(clip_reg[1]);
        cw = (W+1)'(clip_reg[2]);
        sx = cx + cw;
        sy = cw - cy;
        numx_next = sx[W-1:0];
        numy_next = sy[W-1:0];
        tag5_next.vld = ctl4_reg.vld && ctl4_reg.proj;
        if (!mat_valid)
        begin
            tag5_next.status = wtsp_pkg::ST_INVALID;
        end
        else if (clip_reg[2] < ONE_TENTH)
        begin
            tag5_next.status = wtsp_pkg::ST_BEHIND;
        end
        else if ((cx < -cw) || (cx > cw) || (cy < -cw) || (cy > cw))
        begin
            tag5_next.status = wtsp_pkg::ST_OFF_SCREEN;
        end
        else
        begin
            tag5_next.status = wtsp_pkg::ST_ON_SCREEN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            clip_reg <= clip_next;
            numx_reg <= numx_next;
            numy_reg <= numy_next;
            den5_reg <= clip_reg[2];
            dx_reg   <= DW'(numx_reg) * DW'({width, 3'b000});
            dy_reg   <= DW'(numy_reg) * DW'({height, 3'b000});
            den6_reg <= den5_reg;
            if (ctl_in.vld && !ctl_in.proj && ctl_in.cidx[4])
            begin
                coef_reg[ctl_in.cidx[3:0]] <= from32($signed(ctl_in.cval));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            tag5_reg <= '0;
            tag6_reg <= '0;
        end
        else if (adv)
        begin
            ctl3_reg <= ctl_in;
            ctl4_reg <= ctl3_reg;
            tag5_reg <= tag5_next;
            tag6_reg <= tag5_reg;
        end
    end

    assign tag_out = tag6_reg;
    assign dx      = dx_reg;
    assign dy      = dy_reg;
    assign den     = den6_reg;

endmodule

`default_nettype wire

FILE: rtl/core/wtsp_div_step.sv
// ----------------------------------------------------------------------------
// wtsp_div_step
// One restoring-division stage for both screen axes: settles quotient bit BIT.
// ----------------------------------------------------------------------------
`default_nettype none

module wtsp_div_step #(
    parameter int W   = 32,
    parameter int BIT = 0
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  adv,
    input  wire wtsp_pkg::tag_t                        tag_in,
    input  wire logic [W+wtsp_pkg::ScaleW-1:0]         rx_in,
    input  wire logic [W+wtsp_pkg::ScaleW-1:0]         ry_in,
    input  wire logic [wtsp_pkg::QuotW-1:0]            qx_in,
    input  wire logic [wtsp_pkg::QuotW-1:0]            qy_in,
    input  wire logic [W-1:0]                          den_in,
    output      wtsp_pkg::tag_t                        tag_out,
    output      logic [W+wtsp_pkg::ScaleW-1:0]         rx_out,
    output      logic [W+wtsp_pkg::ScaleW-1:0]         ry_out,
    output      logic [wtsp_pkg::QuotW-1:0]            qx_out,
    output      logic [wtsp_pkg::QuotW-1:0]            qy_out,
    output      logic [W-1:0]                          den_out
);

    localparam int DW = W + wtsp_pkg::ScaleW;

    logic [DW:0]                  dsh;
    logic [DW-1:0]                rx_next;
    logic [DW-1:0]                ry_next;
    logic [wtsp_pkg::QuotW-1:0]   qx_next;
    logic [wtsp_pkg::QuotW-1:0]   qy_next;
    logic [DW-1:0]                rx_reg;
    logic [DW-1:0]                ry_reg;
    logic [wtsp_pkg::QuotW-1:0]   qx_reg;
    logic [wtsp_pkg::QuotW-1:0]   qy_reg;
    logic [W-1:0]                 den_reg;
    wtsp_pkg::tag_t               tag_reg;

    always_comb
    begin
        dsh     = (DW+1)'(den_in) << BIT;
        rx_next = rx_in;
        ry_next = ry_in;
        qx_next = qx_in;
        qy_next = qy_in;
        if ({1'b0, rx_in} >= dsh)
        begin
            rx_next     = rx_in - dsh[DW-1:0];
            qx_next[BIT] = 1'b1;
        end
        if ({1'b0, ry_in} >= dsh)
        begin
            ry_next     = ry_in - dsh[DW-1:0];
            qy_next[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            den_reg <= den_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (adv)
        begin
            tag_reg <= tag_in;
        end
    end

    assign tag_out = tag_reg;
    assign rx_out  = rx_reg;
    assign ry_out  = ry_reg;
    assign qx_out  = qx_reg;
    assign qy_out  = qy_reg;
    assign den_out = den_reg;

endmodule

`default_nettype wire

FILE: rtl/core/world_to_screen_projection_core.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection_core
// Fixed-point world-to-screen projection pipeline with coefficient loading.
// ----------------------------------------------------------------------------
// One word is taken every cycle when the output is not stalled; a projected
// point passes through 2 view stages, 4 clip stages, then 17 divider stages,
// one quotient bit each. Coefficient loads (mode 0) use a slot in the pipe
// and give no result. Any stall on the output freezes the whole pipe.
// Registers may be written only while the pipe is empty.
`default_nettype none

module world_to_screen_projection_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output      logic                               in_ready,
    input  wire wtsp_pkg::in_t                      in_data,
    output      logic                               out_valid,
    input  wire logic                               out_ready,
    output      wtsp_pkg::out_t                     out_data,
    input  wire logic                               cfg_we,
    input  wire logic [1:0]                         cfg_index,
    input  wire logic [wtsp_pkg::CfgDataW-1:0]      cfg_data
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + wtsp_pkg::ScaleW;
    localparam int NQ = wtsp_pkg::QuotW;

    logic                              adv;
    logic                              mv_reg;
    logic [wtsp_pkg::CfgDataW-1:0]     width_reg;
    logic [wtsp_pkg::CfgDataW-1:0]     height_reg;
    wtsp_pkg::ctl_t                    ctl_in;
    wtsp_pkg::ctl_t                    ctl_view;
    logic signed [W-1:0]               view_v [4];
    wtsp_pkg::tag_t                    tag_s [NQ+1];
    logic [DW-1:0]                     rx_s [NQ+1];
    logic [DW-1:0]                     ry_s [NQ+1];
    logic [NQ-1:0]                     qx_s [NQ+1];
    logic [NQ-1:0]                     qy_s [NQ+1];
    logic [W-1:0]                      den_s [NQ+1];

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg     <= 1'b0;
            width_reg  <= wtsp_pkg::CfgDataW'(1920);
            height_reg <= wtsp_pkg::CfgDataW'(1080);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wtsp_pkg::CFG_MATRICES_VALID: mv_reg     <= cfg_data[0];
                wtsp_pkg::CFG_SCREEN_WIDTH:   width_reg  <= cfg_data;
                wtsp_pkg::CFG_SCREEN_HEIGHT:  height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign ctl_in.vld  = in_valid;
    assign ctl_in.proj = in_data.mode;
    assign ctl_in.cidx = in_data.coef_index;
    assign ctl_in.cval = in_data.coef_value;

    wtsp_view #(.W(W), .F(FRAC_BITS)) u_view (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .ctl_in   (ctl_in),
        .wx       (in_data.world_x),
        .wy       (in_data.world_y),
        .wz       (in_data.world_z),
        .ctl_out  (ctl_view),
        .view_out (view_v)
    );

    wtsp_clip #(.W(W), .F(FRAC_BITS)) u_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ctl_in    (ctl_view),
        .view_in   (view_v),
        .mat_valid (mv_reg),
        .width     (width_reg),
        .height    (height_reg),
        .tag_out   (tag_s[0]),
        .dx        (rx_s[0]),
        .dy        (ry_s[0]),
        .den       (den_s[0])
    );

    assign qx_s[0] = '0;
    assign qy_s[0] = '0;

    // quotient bits settle from the top down
    for (genvar k = 0; k < NQ; k++)
    begin : g_div
        wtsp_div_step #(.W(W), .BIT(NQ-1-k)) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tag_in  (tag_s[k]),
            .rx_in   (rx_s[k]),
            .ry_in   (ry_s[k]),
            .qx_in   (qx_s[k]),
            .qy_in   (qy_s[k]),
            .den_in  (den_s[k]),
            .tag_out (tag_s[k+1]),
            .rx_out  (rx_s[k+1]),
            .ry_out  (ry_s[k+1]),
            .qx_out  (qx_s[k+1]),
            .qy_out  (qy_s[k+1]),
            .den_out (den_s[k+1])
        );
    end

    assign out_valid       = tag_s[NQ].vld;
    assign out_data.status = tag_s[NQ].status;
    assign out_data.screen_x =
        (tag_s[NQ].status == wtsp_pkg::ST_ON_SCREEN) ? qx_s[NQ] : '0;
    assign out_data.screen_y =
        (tag_s[NQ].status == wtsp_pkg::ST_ON_SCREEN) ? qy_s[NQ] : '0;

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != wtsp_pkg::ST_ON_SCREEN)
            |-> (out_data.screen_x == '0 && out_data.screen_y == '0))
        else $error("rejected point carries nonzero coordinates");

    a_on_needs_mv: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == wtsp_pkg::ST_ON_SCREEN) |-> mv_reg)
        else $error("on-screen result while matrices invalid");

    a_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == wtsp_pkg::ST_ON_SCREEN)
            |-> (out_data.screen_x <= {width_reg, 4'b0000}))
        else $error("screen_x beyond viewport");

    a_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == wtsp_pkg::ST_ON_SCREEN)
            |-> (out_data.screen_y <= {height_reg, 4'b0000}))
        else $error("screen_y beyond viewport");

endmodule

`default_nettype wire
